>>> sv/tcg_pkg.sv
`timescale 1ns / 1ps
package tcg_pkg;

  localparam int INDEX_BITS_DEF  = 16;
  localparam int WHEEL_COUNT_DEF = 3;
  localparam int PHASE_BITS_DEF  = 20;

  // Registered wheels (the register map has three)
  localparam int REG_WHEELS = 3;

  // Turn fraction carried from the parameter multiply onward
  localparam int T_BITS = 36;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;

  // Pipeline depth of one wheel, t in to amp-scaled terms out
  localparam int WHEEL_LAT = 18;

  // Width of one amp * trig term and of the sum over up to eight wheels
  localparam int TERM_W = 48;
  localparam int SUM_W  = 51;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_T_STEP     = 3'd0,
    REG_FREQ0      = 3'd1,
    REG_FREQ1      = 3'd2,
    REG_FREQ2      = 3'd3,
    REG_AMP_PHASE0 = 3'd4,
    REG_AMP_PHASE1 = 3'd5,
    REG_AMP_PHASE2 = 3'd6
  } cfg_reg_e;

  // 2*pi in unsigned Q3.32
  localparam logic [34:0] TAU_Q32 = 35'd26986075409;
  localparam logic [17:0] TAU_LO  = TAU_Q32[17:0];
  localparam logic [16:0] TAU_HI  = TAU_Q32[34:18];

  localparam logic [31:0] Q30_ONE = 32'h4000_0000;

  // Horner divisors
  localparam logic [5:0] DIV_S1 = 6'd42;
  localparam logic [5:0] DIV_S2 = 6'd20;
  localparam logic [5:0] DIV_S3 = 6'd6;
  localparam logic [5:0] DIV_C1 = 6'd56;
  localparam logic [5:0] DIV_C2 = 6'd30;
  localparam logic [5:0] DIV_C3 = 6'd12;

  // Reciprocals floor(2^32 / D)
  localparam logic [31:0] RCP_S1 = 32'(64'h1_0000_0000 / 42);
  localparam logic [31:0] RCP_S2 = 32'(64'h1_0000_0000 / 20);
  localparam logic [31:0] RCP_S3 = 32'(64'h1_0000_0000 / 6);
  localparam logic [31:0] RCP_C1 = 32'(64'h1_0000_0000 / 56);
  localparam logic [31:0] RCP_C2 = 32'(64'h1_0000_0000 / 30);
  localparam logic [31:0] RCP_C3 = 32'(64'h1_0000_0000 / 12);

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [31:0] m;
    logic [31:0] z;
    logic [1:0]  q;
    logic        neg;
  } carry_t;

  // Q2.30 product, both operands below 2^31
  function automatic logic [31:0] mulq30(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[61:30];
  endfunction

  // Quotient estimate, at most one low
  function automatic logic [31:0] rcp_est(logic [31:0] x, logic [31:0] r);
    logic [63:0] p;
    p = x * r;
    return p[63:32];
  endfunction

  function automatic logic [31:0] rcp_fix(logic [31:0] x, logic [31:0] e, logic [5:0] d);
    logic [31:0] rem;
    rem = x - 32'(e * {26'd0, d});
    return (rem >= {26'd0, d}) ? e + 32'd1 : e;
  endfunction

  // Round Q.42 to Q5.12 half up and clamp to 18 bits
  function automatic logic signed [17:0] round_sat(logic signed [SUM_W-1:0] acc);
    logic signed [SUM_W-1:0] r;
    logic signed [SUM_W-31:0] v;
    r = acc + SUM_W'(64'd1 << 29);
    v = r[SUM_W-1:30];
    if (v > (SUM_W-30)'(131071)) begin
      return 18'sd131071;
    end else if (v < -(SUM_W-30)'(131072)) begin
      return -18'sd131072;
    end
    return v[17:0];
  endfunction

endpackage

>>> sv/three_wheel_phasor_curve_gen.sv
`timescale 1ns / 1ps
// Path: an accepted transaction is written into the queue, loaded from its head
// by the first wheel pipeline stage, then passes the sum and output registers.
// Throughput: one point per cycle unless the output stalls; the wheel pipeline
// and the output register advance together, and a four-entry queue keeps the
// input open while they hold, until the queue is full.
// Reset: asynchronous, active low; clears config, queue pointers, valid bits.
module three_wheel_phasor_curve_gen #(
  parameter int INDEX_BITS  = tcg_pkg::INDEX_BITS_DEF,
  parameter int WHEEL_COUNT = tcg_pkg::WHEEL_COUNT_DEF,
  parameter int PHASE_BITS  = tcg_pkg::PHASE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration writes
  input  logic                              cfg_we_i,
  input  logic [tcg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tcg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Sample index channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [INDEX_BITS-1:0]             sample_index_i,
  // Curve point channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [17:0]                x_out_o,
  output logic signed [17:0]                y_out_o
);

  localparam int LAST = tcg_pkg::WHEEL_LAT;

  // Configuration registers; all three wheels are stored whatever the count
  logic [24:0] t_step_q;
  logic [23:0] freq_q [tcg_pkg::REG_WHEELS];
  logic [31:0] ap_q   [tcg_pkg::REG_WHEELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_step_q <= '0;
      for (int k = 0; k < tcg_pkg::REG_WHEELS; k++) begin
        freq_q[k] <= '0;
        ap_q[k]   <= '0;
      end
    end else if (cfg_we_i) begin
      case (tcg_pkg::cfg_reg_e'(cfg_index_i))
        tcg_pkg::REG_T_STEP:     t_step_q  <= cfg_data_i[24:0];
        tcg_pkg::REG_FREQ0:      freq_q[0] <= cfg_data_i[23:0];
        tcg_pkg::REG_FREQ1:      freq_q[1] <= cfg_data_i[23:0];
        tcg_pkg::REG_FREQ2:      freq_q[2] <= cfg_data_i[23:0];
        tcg_pkg::REG_AMP_PHASE0: ap_q[0]   <= cfg_data_i;
        tcg_pkg::REG_AMP_PHASE1: ap_q[1]   <= cfg_data_i;
        tcg_pkg::REG_AMP_PHASE2: ap_q[2]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: accept the index, form t, push into the queue
  tcg_pkg::q_stat_t            q_stat;
  logic                        push, pop;
  logic [tcg_pkg::T_BITS-1:0]  t_push, t_head;

  tcg_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_index_i (sample_index_i),
    .t_step_i       (t_step_q),
    .stat_i         (q_stat),
    .push_o         (push),
    .t_o            (t_push)
  );

  tcg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (t_push),
    .pop_i  (pop),
    .data_o (t_head),
    .stat_o (q_stat)
  );

  // Back: the whole pipeline moves when the output register can take a point
  logic           adv;
  logic [LAST:0]  vld_q;
  logic           out_valid_q;

  assign adv = ~out_valid_q | ~out_stall_i;
  assign pop = adv & ~q_stat.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[LAST-1:0], ~q_stat.empty};
      out_valid_q <= vld_q[LAST];
    end
  end

  logic signed [tcg_pkg::TERM_W-1:0] x_term [WHEEL_COUNT];
  logic signed [tcg_pkg::TERM_W-1:0] y_term [WHEEL_COUNT];

  for (genvar k = 0; k < WHEEL_COUNT; k++) begin : g_wheel
    logic signed [23:0] freq;
    logic [31:0]        ap;
    if (k < tcg_pkg::REG_WHEELS) begin : g_reg
      assign freq = freq_q[k];
      assign ap   = ap_q[k];
    end else begin : g_zero
      // no registers: amplitude zero, contributes nothing
      assign freq = '0;
      assign ap   = '0;
    end
    tcg_wheel #(.PHASE_BITS(PHASE_BITS)) u_wheel (
      .clk_i       (clk_i),
      .en_i        (adv),
      .t_i         (t_head),
      .freq_i      (freq),
      .amp_phase_i (ap),
      .x_term_o    (x_term[k]),
      .y_term_o    (y_term[k])
    );
  end

  // Sum the exact Q.42 terms, then round and clamp into the output register
  logic signed [tcg_pkg::SUM_W-1:0] sx, sy, sx_q, sy_q;
  logic signed [17:0]               x_q, y_q;

  always_comb begin
    sx = '0;
    sy = '0;
    for (int k = 0; k < WHEEL_COUNT; k++) begin
      sx = sx + tcg_pkg::SUM_W'(x_term[k]);
      sy = sy + tcg_pkg::SUM_W'(y_term[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q <= sx;
      sy_q <= sy;
      x_q  <= tcg_pkg::round_sat(sx_q);
      y_q  <= tcg_pkg::round_sat(sy_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_out_o     = x_q;
  assign y_out_o     = y_q;

  // The queue never takes a transaction while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_stat.full)) else $error("queue overflow");

  // The back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_stat.empty)) else $error("queue underflow");

  // A point appears only when the last pipeline stage held one
  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (out_valid_q == $past(vld_q[LAST]))) else $error("output valid mismatch");

  // A held point stays while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(x_q) && $stable(y_q)))
    else $error("output changed under stall");

endmodule

>>> sv/tcg_queue.sv
`timescale 1ns / 1ps
module tcg_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [tcg_pkg::T_BITS-1:0]   data_i,
  input  logic                         pop_i,
  output logic [tcg_pkg::T_BITS-1:0]   data_o,
  output tcg_pkg::q_stat_t             stat_o
);

  logic [tcg_pkg::T_BITS-1:0]  mem_q [tcg_pkg::QUEUE_DEPTH];
  logic [tcg_pkg::QPTR_BITS-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [tcg_pkg::QPTR_BITS:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + {{tcg_pkg::QPTR_BITS{1'b0}}, push_i}
                  - {{tcg_pkg::QPTR_BITS{1'b0}}, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign data_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == (tcg_pkg::QPTR_BITS+1)'(tcg_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

>>> sv/tcg_front.sv
`timescale 1ns / 1ps
module tcg_front #(
  parameter int INDEX_BITS = tcg_pkg::INDEX_BITS_DEF
) (
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [INDEX_BITS-1:0]       sample_index_i,
  input  logic [24:0]                 t_step_i,
  input  tcg_pkg::q_stat_t            stat_i,
  output logic                        push_o,
  output logic [tcg_pkg::T_BITS-1:0]  t_o
);

  logic [INDEX_BITS+24:0] t_full;

  // Only the turn fraction matters downstream; drop whole turns
  assign t_full     = sample_index_i * t_step_i;
  assign t_o        = tcg_pkg::T_BITS'(t_full);
  assign in_stall_o = stat_i.full;
  assign push_o     = in_valid_i & ~stat_i.full;

endmodule

>>> sv/tcg_wheel.sv
`timescale 1ns / 1ps
module tcg_wheel #(
  parameter int PHASE_BITS = tcg_pkg::PHASE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [tcg_pkg::T_BITS-1:0]         t_i,
  input  logic signed [23:0]                 freq_i,
  input  logic [31:0]                        amp_phase_i,
  output logic signed [tcg_pkg::TERM_W-1:0]  x_term_o,
  output logic signed [tcg_pkg::TERM_W-1:0]  y_term_o
);

  localparam int PB = PHASE_BITS;
  localparam logic [PB-1:0] EIGHTH = PB'(1) << (PB - 3);
  localparam logic [17:0] TAU_LO_W = tcg_pkg::TAU_LO;
  localparam logic [16:0] TAU_HI_W = tcg_pkg::TAU_HI;

  // Phase
  logic signed [42:0] plo_full;
  logic [35:0]        phi_full;
  logic [35:0]        plo_q;
  logic [17:0]        phi_q;
  logic [35:0]        ph;
  logic [PB-1:0]      p_q;

  assign plo_full = freq_i * $signed({1'b0, t_i[17:0]});
  assign phi_full = freq_i[17:0] * t_i[35:18];
  assign ph       = plo_q + {phi_q, 18'd0} + {amp_phase_i[15:0], 20'd0};

  // Quadrant reduction
  logic [PB-1:0] u, d, mag;
  logic [1:0]    qd;
  logic [PB-1:0] mag_q;
  logic [1:0]    q3_q, q4_q, q5_q;
  logic          neg3_q, neg4_q, neg5_q;

  always_comb begin
    u   = p_q + EIGHTH;
    qd  = u[PB-1 -: 2];
    d   = p_q - {qd, {(PB-2){1'b0}}};
    mag = d[PB-1] ? (~d + PB'(1)) : d;
  end

  // Radians
  logic [PB+17:0] ml_q;
  logic [PB+16:0] mh_q;
  logic [63:0]    m_full;
  logic [31:0]    m_q;

  assign m_full = (64'(ml_q) + (64'(mh_q) << 18)) >> (PB + 2);

  // Kernels
  tcg_pkg::carry_t cr_q [11];
  logic [31:0] s_e1_q, c_e1_q, s_a1_q, c_a1_q;
  logic [31:0] s_p2_q, c_p2_q, s_e2_q, c_e2_q, s_x2_q, c_x2_q, s_a2_q, c_a2_q;
  logic [31:0] s_p3_q, c_p3_q, s_e3_q, c_e3_q, s_x3_q, c_x3_q, s_a3_q, c_a3_q;
  logic [31:0] s_v_q, c_p4_q, s_v2_q, c_v_q;
  logic signed [31:0] rs_q, rc_q;
  logic signed [31:0] sv, rs, rc;
  logic signed [15:0] amp;

  assign amp = amp_phase_i[31:16];

  always_comb begin
    sv = cr_q[10].neg ? -$signed(s_v2_q) : $signed(s_v2_q);
    rs = cr_q[10].q[0] ? $signed(c_v_q) : sv;
    rc = cr_q[10].q[0] ? sv : $signed(c_v_q);
    if (cr_q[10].q[1]) begin
      rs = -rs;
    end
    if (cr_q[10].q[1] ^ cr_q[10].q[0]) begin
      rc = -rc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q  <= plo_full[35:0];
      phi_q  <= phi_full[17:0];
      p_q    <= ph[35 -: PB];
      mag_q  <= mag;
      q3_q   <= qd;
      neg3_q <= d[PB-1];
      ml_q   <= mag_q * TAU_LO_W;
      mh_q   <= mag_q * TAU_HI_W;
      q4_q   <= q3_q;
      neg4_q <= neg3_q;
      m_q    <= {2'b00, m_full[29:0]};
      q5_q   <= q4_q;
      neg5_q <= neg4_q;
      cr_q[0] <= '{m: m_q, z: tcg_pkg::mulq30(m_q, m_q), q: q5_q, neg: neg5_q};
      for (int j = 1; j < 11; j++) begin
        cr_q[j] <= cr_q[j-1];
      end
      // level one: 1 - z/D
      s_e1_q <= tcg_pkg::rcp_est(cr_q[0].z, tcg_pkg::RCP_S1);
      c_e1_q <= tcg_pkg::rcp_est(cr_q[0].z, tcg_pkg::RCP_C1);
      s_a1_q <= tcg_pkg::Q30_ONE - tcg_pkg::rcp_fix(cr_q[1].z, s_e1_q, tcg_pkg::DIV_S1);
      c_a1_q <= tcg_pkg::Q30_ONE - tcg_pkg::rcp_fix(cr_q[1].z, c_e1_q, tcg_pkg::DIV_C1);
      // level two
      s_p2_q <= tcg_pkg::mulq30(cr_q[2].z, s_a1_q);
      c_p2_q <= tcg_pkg::mulq30(cr_q[2].z, c_a1_q);
      s_e2_q <= tcg_pkg::rcp_est(s_p2_q, tcg_pkg::RCP_S2);
      c_e2_q <= tcg_pkg::rcp_est(c_p2_q, tcg_pkg::RCP_C2);
      s_x2_q <= s_p2_q;
      c_x2_q <= c_p2_q;
      s_a2_q <= tcg_pkg::Q30_ONE - tcg_pkg::rcp_fix(s_x2_q, s_e2_q, tcg_pkg::DIV_S2);
      c_a2_q <= tcg_pkg::Q30_ONE - tcg_pkg::rcp_fix(c_x2_q, c_e2_q, tcg_pkg::DIV_C2);
      // level three
      s_p3_q <= tcg_pkg::mulq30(cr_q[5].z, s_a2_q);
      c_p3_q <= tcg_pkg::mulq30(cr_q[5].z, c_a2_q);
      s_e3_q <= tcg_pkg::rcp_est(s_p3_q, tcg_pkg::RCP_S3);
      c_e3_q <= tcg_pkg::rcp_est(c_p3_q, tcg_pkg::RCP_C3);
      s_x3_q <= s_p3_q;
      c_x3_q <= c_p3_q;
      s_a3_q <= tcg_pkg::Q30_ONE - tcg_pkg::rcp_fix(s_x3_q, s_e3_q, tcg_pkg::DIV_S3);
      c_a3_q <= tcg_pkg::Q30_ONE - tcg_pkg::rcp_fix(c_x3_q, c_e3_q, tcg_pkg::DIV_C3);
      // finish: sin = m*a, cos = 1 - z*a/2
      s_v_q  <= tcg_pkg::mulq30(cr_q[8].m, s_a3_q);
      c_p4_q <= tcg_pkg::mulq30(cr_q[8].z, c_a3_q);
      s_v2_q <= s_v_q;
      c_v_q  <= tcg_pkg::Q30_ONE - (c_p4_q >> 1);
      rs_q   <= rs;
      rc_q   <= rc;
      x_term_o <= amp * rc_q;
      y_term_o <= amp * rs_q;
    end
  end

endmodule
